// ----- hw/rtl/fudc_pkg.sv -----
// ----------------------------------------------------------------------------
// fudc_pkg
// Shared codes and field widths for the framed byte receiver with sum and
// add checks.
// ----------------------------------------------------------------------------
package fudc_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned PhaseWidth  = 3;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned IndexWidth  = 1;

   // rsp tdata: payload_byte, byte_index, function_id, payload_length,
   // frame_status = 34 bits, padded to 5 bytes
   localparam int unsigned RspDataWidth = 40;

   // parser phases
   localparam logic [PhaseWidth-1:0] PH_HUNT = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_ADDR = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_ID   = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_LEN  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_DATA = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_SUM  = 3'd5;
   localparam logic [PhaseWidth-1:0] PH_ADD  = 3'd6;

   // result kinds (rsp_tuser)
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict status codes
   localparam logic [StatusWidth-1:0] STAT_GOOD     = 2'd0;
   localparam logic [StatusWidth-1:0] STAT_SUM_FAIL = 2'd1;
   localparam logic [StatusWidth-1:0] STAT_ADD_FAIL = 2'd2;

   // configuration register indexes
   localparam logic [IndexWidth-1:0] REG_HEADER  = 1'd0;
   localparam logic [IndexWidth-1:0] REG_ADDRESS = 1'd1;

   localparam logic [ByteWidth-1:0] HeaderReset  = 8'd170;
   localparam logic [ByteWidth-1:0] AddressReset = 8'd255;

endpackage

// ----- hw/rtl/framed_uart_receiver_dual_checksum_unit.sv -----
// ----------------------------------------------------------------------------
// framed_uart_receiver_dual_checksum_unit
// Byte-stream frame parser: header, address, function id, length, payload,
// sum check, add check. Streams payload beats and one verdict per frame.
// ----------------------------------------------------------------------------
// Takes one received byte per req beat and can accept a byte every clock
// cycle unless the rsp output register is full and stalled. Each byte is
// parsed in the cycle it is accepted; a resulting beat (payload byte or
// end-of-frame verdict) lands in the rsp output register in the next cycle.
// req_tready is high whenever that output register is empty or is being
// drained in the same cycle, so back-to-back bytes flow at full rate as long
// as the sink keeps rsp_tready high. Payload beats carry kind 0 with the byte
// and its index; the verdict (kind 1) carries status good, sum check mismatch
// or add check mismatch (sum mismatch wins if both fail). The sink should
// commit a frame's payload only on a good verdict. A failed address byte drops
// the frame; if it equals the header value it restarts a frame. Header and
// address values are written through the csr port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module framed_uart_receiver_dual_checksum_unit
   import fudc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // byte input
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ByteWidth-1:0]    req_tdata,   // [7:0] rx_byte
   // result output
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // [7:0] payload_byte,
                                                // [15:8] byte_index,
                                                // [23:16] func_id,
                                                // [31:24] payload_length,
                                                // [33:32] frame_status,
                                                // [39:34] zero
   output logic                    rsp_tuser,   // [0] result_kind
   // configuration
   input  logic                    csr_we,
   input  logic [IndexWidth-1:0]   csr_index,
   input  logic [ByteWidth-1:0]    csr_wdata
);

   // config registers
   logic [ByteWidth-1:0] header_ff,  header_in;
   logic [ByteWidth-1:0] address_ff, address_in;

   // parser state
   logic [PhaseWidth-1:0] phase_ff,   phase_in;
   logic [ByteWidth-1:0]  fid_ff,     fid_in;
   logic [ByteWidth-1:0]  flen_ff,    flen_in;
   logic [ByteWidth-1:0]  seen_ff,    seen_in;
   logic [ByteWidth-1:0]  sum_ff,     sum_in;
   logic [ByteWidth-1:0]  add_ff,     add_in;
   logic                  sfail_ff,   sfail_in;

   // output register
   logic                   ovalid_ff,  ovalid_in;
   logic                   okind_ff,   okind_in;
   logic [ByteWidth-1:0]   obyte_ff,   obyte_in;
   logic [ByteWidth-1:0]   oidx_ff,    oidx_in;
   logic [ByteWidth-1:0]   ofid_ff,    ofid_in;
   logic [ByteWidth-1:0]   olen_ff,    olen_in;
   logic [StatusWidth-1:0] ostat_ff,   ostat_in;

   logic                 accept;
   logic                 emit;
   logic [ByteWidth-1:0] rx;
   logic [ByteWidth-1:0] acc_sum;    // running sum with this byte added
   logic [ByteWidth-1:0] acc_add;
   logic [ByteWidth-1:0] seen_inc;

   assign req_tready = !ovalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign acc_sum    = sum_ff + rx;
   assign acc_add    = add_ff + acc_sum;
   assign seen_inc   = seen_ff + 8'd1;

   // config writes; index beyond the list is ignored by the decode
   always_comb begin
      header_in  = header_ff;
      address_in = address_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_HEADER:  header_in  = csr_wdata;
            REG_ADDRESS: address_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // one byte of parsing
   always_comb begin
      phase_in = phase_ff;
      fid_in   = fid_ff;
      flen_in  = flen_ff;
      seen_in  = seen_ff;
      sum_in   = sum_ff;
      add_in   = add_ff;
      sfail_in = sfail_ff;
      emit     = 1'b0;
      okind_in = KIND_PAYLOAD;
      obyte_in = '0;
      oidx_in  = '0;
      ofid_in  = fid_ff;
      olen_in  = flen_ff;
      ostat_in = STAT_GOOD;

      if (accept) begin
         unique case (phase_ff)
            PH_ADDR: begin
               // address match has priority over a header restart
               if (rx == address_ff) begin
                  sum_in   = acc_sum;
                  add_in   = acc_add;
                  phase_in = PH_ID;
               end else if (rx == header_ff) begin
                  sum_in   = rx;
                  add_in   = rx;
                  sfail_in = 1'b0;
                  phase_in = PH_ADDR;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_ID: begin
               sum_in   = acc_sum;
               add_in   = acc_add;
               fid_in   = rx;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               sum_in   = acc_sum;
               add_in   = acc_add;
               flen_in  = rx;
               seen_in  = '0;
               phase_in = (rx == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               sum_in   = acc_sum;
               add_in   = acc_add;
               emit     = 1'b1;
               okind_in = KIND_PAYLOAD;
               obyte_in = rx;
               oidx_in  = seen_ff;
               seen_in  = seen_inc;
               if (seen_inc == flen_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               sfail_in = (rx != sum_ff);
               phase_in = PH_ADD;
            end
            PH_ADD: begin
               emit     = 1'b1;
               okind_in = KIND_VERDICT;
               if (sfail_ff) begin
                  ostat_in = STAT_SUM_FAIL;
               end else if (rx != add_ff) begin
                  ostat_in = STAT_ADD_FAIL;
               end else begin
                  ostat_in = STAT_GOOD;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               // hunting for a header (also catches the unused code)
               if (rx == header_ff) begin
                  sum_in   = rx;
                  add_in   = rx;
                  sfail_in = 1'b0;
                  phase_in = PH_ADDR;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   // output slot: load on a beat-producing byte, clear when drained
   always_comb begin
      ovalid_in = ovalid_ff;
      if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
      if (emit) begin
         ovalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HeaderReset;
         address_ff <= AddressReset;
         phase_ff   <= PH_HUNT;
         fid_ff     <= '0;
         flen_ff    <= '0;
         seen_ff    <= '0;
         sum_ff     <= '0;
         add_ff     <= '0;
         sfail_ff   <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         header_ff  <= header_in;
         address_ff <= address_in;
         phase_ff   <= phase_in;
         fid_ff     <= fid_in;
         flen_ff    <= flen_in;
         seen_ff    <= seen_in;
         sum_ff     <= sum_in;
         add_ff     <= add_in;
         sfail_ff   <= sfail_in;
         ovalid_ff  <= ovalid_in;
      end
   end

   // beat payload, no reset needed
   always_ff @(posedge clock) begin
      if (emit) begin
         okind_ff <= okind_in;
         obyte_ff <= obyte_in;
         oidx_ff  <= oidx_in;
         ofid_ff  <= ofid_in;
         olen_ff  <= olen_in;
         ostat_ff <= ostat_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tdata  = {6'd0, ostat_ff, olen_ff, ofid_ff, oidx_ff, obyte_ff};

endmodule

// ----- hw/rtl/fudc_checker.sv -----
// ----------------------------------------------------------------------------
// fudc_checker
// Port-level checks for the framed byte receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fudc_checker
   import fudc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tuser
);

   logic [ByteWidth-1:0]   c_byte;
   logic [ByteWidth-1:0]   c_idx;
   logic [ByteWidth-1:0]   c_len;
   logic [StatusWidth-1:0] c_stat;

   assign c_byte = rsp_tdata[7:0];
   assign c_idx  = rsp_tdata[15:8];
   assign c_len  = rsp_tdata[31:24];
   assign c_stat = rsp_tdata[33:32];

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // payload beats sit inside the declared length and carry good status
   a_payload_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD |-> c_idx < c_len && c_stat == STAT_GOOD)
      else $error("payload beat index or status out of range");

   // verdict beats carry a known status and zero byte fields
   a_verdict_fmt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_VERDICT |->
         (c_stat == STAT_GOOD || c_stat == STAT_SUM_FAIL || c_stat == STAT_ADD_FAIL)
         && c_byte == '0 && c_idx == '0)
      else $error("malformed verdict beat");

   // an empty output slot never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output slot");

   // no beat appears unless a byte was taken
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(req_tvalid && req_tready))
      else $error("rsp beat without an accepted byte");

endmodule

bind framed_uart_receiver_dual_checksum_unit fudc_checker u_fudc_checker (.*);
